// ----- rtl/core/lkt_pkg.sv -----
package lkt_pkg;

    // Default table size and the fixed field widths of the stream beats
    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int CAP_W       = 5;
    localparam int CAP_RESET   = 4;
    localparam int RANK_OUT_W  = 4;
    localparam int OCC_OUT_W   = 5;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 48;
    localparam int M_USER_W    = 2;

    // Bit positions inside the result beat
    localparam int M_RANK_LSB = 0;
    localparam int M_KEY_LSB  = 4;
    localparam int M_OCC_LSB  = 36;
    localparam int M_USER_HIT = 0;
    localparam int M_USER_EVT = 1;

    typedef logic signed [KEY_W-1:0] key_t;

    // Update command broadcast to every table entry
    typedef struct packed {
        logic go;       // an access commits this cycle
        logic hit;      // key was found: age entries newer than it
        logic age_all;  // key gets inserted: age every held entry
    } cell_cmd_t;

    // Status returned by every table entry
    typedef struct packed {
        logic valid;    // entry holds a key
        logic match;    // entry holds the key of the current access
        logic last;     // entry is the least recently used one
    } cell_stat_t;

endpackage

// ----- rtl/core/lkt_cell.sv -----
module lkt_cell #(
    parameter int RANK_W = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lkt_pkg::key_t       key,
    input  logic [RANK_W-1:0]   hit_rank,
    input  logic [RANK_W-1:0]   last_rank,
    input  lkt_pkg::cell_cmd_t  cmd,
    input  logic                load,
    output lkt_pkg::cell_stat_t stat,
    output lkt_pkg::key_t       key_out,
    output logic [RANK_W-1:0]   rank_out
);

    logic                valid_reg;
    lkt_pkg::key_t       key_reg;
    logic [RANK_W-1:0]   rank_reg;

    // Report match and least recent position to the controller
    assign stat.valid = valid_reg;
    assign stat.match = valid_reg && (key_reg == key);
    assign stat.last  = valid_reg && (rank_reg == last_rank);
    assign key_out    = key_reg;
    assign rank_out   = rank_reg;

    // Hold the valid mark; set it when this entry takes a key
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.go && load) begin
            valid_reg <= 1'b1;
        end
    end

    // Load the key as most recent, or age it by one step
    always_ff @(posedge aclk) begin
        if (cmd.go) begin
            if (load) begin
                key_reg  <= key;
                rank_reg <= '0;
            end else if (valid_reg && cmd.hit && (rank_reg < hit_rank)) begin
                rank_reg <= rank_reg + RANK_W'(1);
            end else if (valid_reg && cmd.age_all) begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/lkt_ctrl.sv -----
module lkt_ctrl #(
    parameter int ENTRIES = lkt_pkg::ENTRIES_DEF,
    parameter int RANK_W  = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 go,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lkt_pkg::CAP_W-1:0]            cfg_data,
    input  lkt_pkg::cell_stat_t [ENTRIES-1:0]    stat,
    input  lkt_pkg::key_t [ENTRIES-1:0]          keys,
    input  logic [ENTRIES-1:0][RANK_W-1:0]       ranks,
    output lkt_pkg::cell_cmd_t                   cmd,
    output logic [ENTRIES-1:0]                   load,
    output logic [RANK_W-1:0]                    hit_rank,
    output logic [RANK_W-1:0]                    last_rank,
    output logic                                 hit,
    output logic                                 evicted,
    output lkt_pkg::key_t                        evicted_key,
    output logic [CNT_W-1:0]                     occupancy
);

    localparam int CAP_RST = (lkt_pkg::CAP_RESET > ENTRIES) ? ENTRIES : lkt_pkg::CAP_RESET;

    logic [CNT_W-1:0]   held_reg;
    logic [CNT_W-1:0]   held_next;
    logic [CNT_W-1:0]   cap_reg;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] last_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_first;
    logic [ENTRIES-1:0] ins_vec;
    logic               full;
    logic               insert;

    // Gather per-entry status
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = stat[i].match;
            last_vec[i]  = stat[i].last;
            free_vec[i]  = !stat[i].valid;
        end
    end

    // Isolate the lowest free entry
    assign free_first = free_vec & (~free_vec + ENTRIES'(1));

    assign last_rank = RANK_W'(held_reg - CNT_W'(1));
    assign full      = (held_reg >= cap_reg) && (held_reg != '0);
    assign hit       = |match_vec;
    assign evicted   = !hit && full && (|last_vec);
    assign insert    = !hit && (evicted || (|free_vec));
    assign ins_vec   = evicted ? last_vec : free_first;

    // Pick the entry that takes the key as most recent
    always_comb begin
        if (hit) begin
            load = match_vec;
        end else if (insert) begin
            load = ins_vec;
        end else begin
            load = '0;
        end
    end

    assign cmd.go      = go;
    assign cmd.hit     = hit;
    assign cmd.age_all = insert;

    // Select the rank of the hit entry and the key of the evicted one
    always_comb begin
        hit_rank    = '0;
        evicted_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_vec[i]) begin
                hit_rank = hit_rank | ranks[i];
            end
            if (evicted && last_vec[i]) begin
                evicted_key = evicted_key | keys[i];
            end
        end
    end

    // Count grows only when a key enters a free entry
    assign held_next = (insert && !evicted) ? held_reg + CNT_W'(1) : held_reg;
    assign occupancy = held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (go) begin
            held_reg <= held_next;
        end
    end

    // Capacity: take writes only while the table is empty, clamp to 1..ENTRIES
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CNT_W'(CAP_RST);
        end else if (cfg_valid && cfg_ready && (held_reg == '0)) begin
            if (cfg_data == '0) begin
                cap_reg <= CNT_W'(1);
            end else if (32'(cfg_data) > ENTRIES) begin
                cap_reg <= CNT_W'(ENTRIES);
            end else begin
                cap_reg <= CNT_W'(cfg_data);
            end
        end
    end

endmodule

// ----- rtl/core/lru_key_tracker.sv -----
// LRU key tracker.
// Each beat on the s_ channel carries one 32-bit key. The block answers every
// key with one beat on the m_ channel: hit flag and former recency rank
// (0 = most recent), the evicted least recently used key if the table was
// full, and the number of keys held after the access.
// The cfg channel writes the capacity (1..ENTRIES, clamped); a write is
// dropped while any key is held. cfg_ready is always high.
// An accepted key waits in the input register; its result is then captured in
// the result register, which drives the m_ channel.
// Throughput: one key per cycle while the receiver does not stall; the whole
// table compare, rank update and victim selection are one combinational pass
// between input and result register.
// Reset (aresetn low, synchronous) clears all valid marks, the held count and
// both stage valids, and sets capacity to 4 (or ENTRIES if smaller).
// When the receiver stalls, the result register holds its beat, the input
// register keeps one more key, and s_tready then drops until m_tready rises.
module lru_key_tracker #(
    parameter int ENTRIES = lkt_pkg::ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: access_key [31:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lkt_pkg::S_DATA_W-1:0]      s_tdata,
    // m_tdata: hit_rank [3:0], evicted_key [35:4], occupancy [40:36], zero [47:41]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lkt_pkg::M_DATA_W-1:0]      m_tdata,
    // m_tuser: hit [0], evicted [1]
    output logic [lkt_pkg::M_USER_W-1:0]      m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lkt_pkg::CAP_W-1:0]         cfg_data
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    logic                                in_valid_reg;
    lkt_pkg::key_t                       in_key_reg;
    logic                                out_valid_reg;
    logic                                out_hit_reg;
    logic                                out_evt_reg;
    logic [lkt_pkg::RANK_OUT_W-1:0]      out_rank_reg;
    lkt_pkg::key_t                       out_key_reg;
    logic [lkt_pkg::OCC_OUT_W-1:0]       out_occ_reg;
    logic                                out_free;
    logic                                go;

    lkt_pkg::cell_cmd_t                  cmd;
    lkt_pkg::cell_stat_t [ENTRIES-1:0]   stat;
    lkt_pkg::key_t [ENTRIES-1:0]         keys;
    logic [ENTRIES-1:0][RANK_W-1:0]      ranks;
    logic [ENTRIES-1:0]                  load;
    logic [RANK_W-1:0]                   hit_rank;
    logic [RANK_W-1:0]                   last_rank;
    logic                                hit;
    logic                                evicted;
    lkt_pkg::key_t                       evicted_key;
    logic [CNT_W-1:0]                    occupancy;

    // Advance the input beat into the result register when it has room
    assign out_free = !out_valid_reg || m_tready;
    assign go       = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_key_reg <= lkt_pkg::key_t'(s_tdata[lkt_pkg::KEY_W-1:0]);
        end
    end

    // Table of entries
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkt_cell #(
            .RANK_W(RANK_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .key      (in_key_reg),
            .hit_rank (hit_rank),
            .last_rank(last_rank),
            .cmd      (cmd),
            .load     (load[g]),
            .stat     (stat[g]),
            .key_out  (keys[g]),
            .rank_out (ranks[g])
        );
    end

    lkt_ctrl #(
        .ENTRIES(ENTRIES),
        .RANK_W (RANK_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .go         (go),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .stat       (stat),
        .keys       (keys),
        .ranks      (ranks),
        .cmd        (cmd),
        .load       (load),
        .hit_rank   (hit_rank),
        .last_rank  (last_rank),
        .hit        (hit),
        .evicted    (evicted),
        .evicted_key(evicted_key),
        .occupancy  (occupancy)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            out_hit_reg  <= hit;
            out_evt_reg  <= evicted;
            out_rank_reg <= lkt_pkg::RANK_OUT_W'(hit_rank);
            out_key_reg  <= evicted_key;
            out_occ_reg  <= lkt_pkg::OCC_OUT_W'(occupancy);
        end
    end

    // Pack the result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_occ_reg, out_key_reg, out_rank_reg};
    assign m_tuser  = {out_evt_reg, out_hit_reg};

endmodule

// ----- rtl/core/lkt_checker.sv -----
module lkt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lkt_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [lkt_pkg::M_USER_W-1:0]  m_tuser
);

    // A stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed under stall");

    // A hit never evicts
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[lkt_pkg::M_USER_HIT] && m_tuser[lkt_pkg::M_USER_EVT]))
        else $error("hit and eviction in one result");

    // A miss reports rank zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[lkt_pkg::M_USER_HIT] |-> m_tdata[3:0] == 4'd0)
        else $error("nonzero rank on a miss");

    // No eviction reports key zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[lkt_pkg::M_USER_EVT] |-> m_tdata[35:4] == 32'd0)
        else $error("evicted key set without eviction");

    // After any access at least one key is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[40:36] != 5'd0 || m_tdata[3:0] != 4'd0 ||
                     m_tuser[lkt_pkg::M_USER_HIT] || m_tuser[lkt_pkg::M_USER_EVT] ||
                     m_tdata[35:4] != 32'd0)
        else $error("empty table after an access");

endmodule

bind lru_key_tracker lkt_checker u_lkt_checker (.*);
